FILE: sv/nbgc_pkg.sv
// Shared types, codes and constants for the narrow-band grid compaction block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nbgc_pkg;

	// Default sizing handed to the top-level parameters
	localparam int MAX_NODES_DEF    = 8192;
	localparam int MAX_EXPONENT_DEF = 6;

	// Fixed field widths
	localparam int EXP_W     = 3;
	localparam int LIMIT_W   = 23;
	localparam int DIST_W    = 24;
	localparam int IDX_W     = 13;
	localparam int COUNT_W   = 14;
	localparam int NBR_SLOTS = 6;

	// Last neighbor slot walked per query
	localparam logic [2:0] LAST_SLOT_2D = 3'd3;
	localparam logic [2:0] LAST_SLOT_3D = 3'd5;

	typedef enum logic [1:0] {
		REQ_RESTART = 2'd0,
		REQ_LOAD    = 2'd1,
		REQ_QUERY   = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_LOAD_FULL   = 2'd1,
		STS_QUERY_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_BAND_LIMIT = 2'd0,
		CFG_THREE_DIMS = 2'd1,
		CFG_GRID_EXP   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_ISSUE = 2'd1,
		S_DRAIN = 2'd2
	} state_t;

	// Input transaction
	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DIST_W-1:0] distance;
		logic [IDX_W-1:0]         entry_index;
	} nbgc_in_t;

	// Result transaction
	typedef struct packed {
		logic [1:0]           status;
		logic                 in_band;
		logic [IDX_W-1:0]     band_index;
		logic [IDX_W-1:0]     grid_index;
		logic [NBR_SLOTS-1:0] nbr_valid;
		logic [IDX_W-1:0]     nbr_plus_i;
		logic [IDX_W-1:0]     nbr_minus_i;
		logic [IDX_W-1:0]     nbr_plus_j;
		logic [IDX_W-1:0]     nbr_minus_j;
		logic [IDX_W-1:0]     nbr_plus_k;
		logic [IDX_W-1:0]     nbr_minus_k;
		logic [COUNT_W-1:0]   band_count;
	} nbgc_out_t;

	// Neighbor slot issued into the address pipeline
	typedef struct packed {
		logic       vld;
		logic       last;
		logic [2:0] slot;
	} nbgc_issue_t;

	// Slot tag traveling along the address pipeline
	typedef struct packed {
		logic       vld;
		logic       last;
		logic       ok;
		logic [2:0] slot;
	} nbgc_tag_t;

endpackage

`default_nettype wire

FILE: sv/nbgc_nbr_pipe.sv
// Two-stage neighbor address pipeline: neighbor coordinates, grid bounds check,
// row-major index and node table read request. Depends on nbgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nbgc_nbr_pipe import nbgc_pkg::*; #(
	parameter int MAX_NODES    = MAX_NODES_DEF,
	parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  nbgc_issue_t                             issue,
	input  logic [2:0][MAX_EXPONENT:0]              coord,
	input  logic [EXP_W-1:0]                        exp_eff,
	input  logic [MAX_EXPONENT:0]                   side,
	input  logic                                    three_dims,
	input  logic [$clog2(MAX_NODES+1)-1:0]          load_pos,
	output logic                                    tbl_re,
	output logic [$clog2(MAX_NODES)-1:0]            tbl_raddr,
	output nbgc_tag_t                               tag_s2
);

	localparam int AW   = $clog2(MAX_NODES);
	localparam int PW   = $clog2(MAX_NODES + 1);
	localparam int CW   = MAX_EXPONENT + 1;
	localparam int NW   = 3 * CW;
	localparam int CMPW = (NW > PW) ? NW : PW;

	logic [1:0]          axis;
	logic                minus;
	logic [2:0][CW:0]    ncw;
	logic                in_grid;
	logic [2*CW-1:0]     lin_ij;

	nbgc_tag_t           tag_s1;
	logic [2*CW-1:0]     lin_s1;
	logic [CW-1:0]       k_s1;

	logic [NW-1:0]       lin_idx;
	logic                loaded;

	// Stage 1: step one axis, check every used axis against the side, fold i and j
	always_comb begin
		axis    = issue.slot[2:1];
		minus   = issue.slot[0];
		in_grid = 1'b1;
		for (int d = 0; d < 3; d++) begin
			ncw[d] = {1'b0, coord[d]};
			if (axis == 2'(d)) begin
				// a step below zero wraps to all ones and fails the bound
				ncw[d] = minus ? ncw[d] - (CW+1)'(1) : ncw[d] + (CW+1)'(1);
			end
			if ((d < 2 || three_dims) && ncw[d] >= {1'b0, side}) begin
				in_grid = 1'b0;
			end
		end
		// i * side + j, side being 2^e + 1
		lin_ij = ((2*CW)'(ncw[0][CW-1:0]) << exp_eff) + (2*CW)'(ncw[0][CW-1:0])
			+ (2*CW)'(ncw[1][CW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld  <= issue.vld;
			tag_s1.last <= issue.last;
			tag_s1.ok   <= in_grid;
			tag_s1.slot <= issue.slot;
		end
	end

	always_ff @(posedge clk) begin
		lin_s1 <= lin_ij;
		k_s1   <= ncw[2][CW-1:0];
	end

	// Stage 2: full row-major index, must lie below the load position
	always_comb begin
		if (three_dims) begin
			lin_idx = (NW'(lin_s1) << exp_eff) + NW'(lin_s1) + NW'(k_s1);
		end else begin
			lin_idx = NW'(lin_s1);
		end
		loaded    = CMPW'(lin_idx) < CMPW'(load_pos);
		tbl_re    = tag_s1.vld;
		tbl_raddr = AW'(lin_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2.vld  <= tag_s1.vld;
			tag_s2.last <= tag_s1.last;
			tag_s2.ok   <= tag_s1.ok && loaded;
			tag_s2.slot <= tag_s1.slot;
		end
	end

endmodule

`default_nettype wire

FILE: sv/narrow_band_grid_compaction.sv
// Top level of the narrow-band grid compaction block: config registers, node
// table and band entry memories, load datapath and query sequencer.
// Depends on nbgc_pkg and nbgc_nbr_pipe.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input: a transaction is taken at a rising edge with start high and busy low.
//   req.req_type selects restart, load one node distance, or query a band entry.
//   Output: each transaction gives exactly one result, shown on result for one
//   cycle with done high; the receiver cannot stall it.
//   Config: cfg_we writes cfg_wdata to register cfg_index at the edge (0 band
//   limit, 1 three-dimensional select, 2 grid exponent); write only while idle.
//   Restart, load and rejected transactions never raise busy: done follows the
//   accepting edge, so one may be taken every cycle.
//   A query reads its band entry from one memory, then walks 4 (2D) or 6 (3D)
//   neighbor slots, one per cycle, through a two-stage address pipeline into
//   the single read port of the node table; busy is high from acceptance
//   until the result is shown. That read port sets the query rate.
//   Reset clears the load position, band count, coordinates and configuration
//   (grid exponent resets to 4). Memories are not cleared: only entries written
//   since the last restart or reset are ever used.

module narrow_band_grid_compaction import nbgc_pkg::*; #(
	parameter int MAX_NODES    = MAX_NODES_DEF,
	parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  nbgc_in_t           req,
	output logic               done,
	output nbgc_out_t          result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	localparam int AW    = $clog2(MAX_NODES);
	localparam int PW    = $clog2(MAX_NODES + 1);
	localparam int CW    = MAX_EXPONENT + 1;
	localparam int NW    = 3 * CW;
	localparam int CMPW  = (NW > PW) ? NW : PW;
	localparam int QW    = (PW > IDX_W) ? PW : IDX_W;
	localparam int TW    = AW + 1;
	localparam int ENT_W = AW + 3 * CW;

	// Configuration registers
	logic [LIMIT_W-1:0] band_limit_q;
	logic               three_dims_q;
	logic [EXP_W-1:0]   grid_exp_q;

	// Load state
	logic [PW-1:0]         load_pos_q;
	logic [PW-1:0]         band_total_q;
	logic [2:0][CW-1:0]    coord_q;

	// Derived grid geometry
	logic [EXP_W-1:0]   exp_eff;
	logic [CW-1:0]      side;
	logic [2*CW-1:0]    side_sq;
	logic [NW-1:0]      node_cnt;

	// Load datapath
	logic                  accept;
	logic                  load_full;
	logic [DIST_W-1:0]     dist_raw;
	logic [DIST_W-1:0]     dist_mag;
	logic                  take;
	logic                  query_oob;
	logic                  query_go;
	logic [2:0][CW-1:0]    coord_adv;
	logic [PW-1:0]         pos_d;
	logic [PW-1:0]         total_d;
	logic [2:0][CW-1:0]    coord_d;
	nbgc_out_t             imm_res;

	// Memories and their ports
	logic [TW-1:0]    node_tbl [MAX_NODES];
	logic [ENT_W-1:0] entry_mem [MAX_NODES];
	logic             tbl_we;
	logic [AW-1:0]    tbl_waddr;
	logic [TW-1:0]    tbl_wdata;
	logic             tbl_re;
	logic [AW-1:0]    tbl_raddr;
	logic [TW-1:0]    tbl_rd_q;
	logic             ent_we;
	logic [ENT_W-1:0] ent_wdata;
	logic [ENT_W-1:0] ent_rd_q;
	logic [AW-1:0]    ent_gidx;
	logic [2:0][CW-1:0] ent_coord;

	// Query sequencer
	state_t       state_q;
	state_t       state_d;
	logic [2:0]   slot_q;
	logic [2:0]   slot_d;
	logic [2:0]   last_slot;
	nbgc_issue_t  issue;
	nbgc_tag_t    tag_s2;
	logic         hit;
	logic         query_end;

	// Neighbor collection and result
	logic [NBR_SLOTS-1:0]             nvalid_q;
	logic [NBR_SLOTS-1:0]             nv_d;
	logic [NBR_SLOTS-1:0][IDX_W-1:0]  nbr_q;
	logic [NBR_SLOTS-1:0][IDX_W-1:0]  nb_d;
	nbgc_out_t                        qry_res;
	nbgc_out_t                        res_q;
	logic                             done_q;

	// Configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_limit_q <= '0;
			three_dims_q <= 1'b0;
			grid_exp_q   <= EXP_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BAND_LIMIT: band_limit_q <= cfg_wdata;
				CFG_THREE_DIMS: three_dims_q <= cfg_wdata[0];
				CFG_GRID_EXP:   grid_exp_q   <= cfg_wdata[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	// Grid side 2^e + 1 with the exponent clamped, and node count
	always_comb begin
		exp_eff = grid_exp_q;
		if (grid_exp_q == '0) begin
			exp_eff = EXP_W'(1);
		end else if (32'(grid_exp_q) > MAX_EXPONENT) begin
			exp_eff = EXP_W'(MAX_EXPONENT);
		end
		side    = (CW'(1) << exp_eff) + CW'(1);
		side_sq = ((2*CW)'(side) << exp_eff) + (2*CW)'(side);
		if (three_dims_q) begin
			node_cnt = (NW'(side_sq) << exp_eff) + NW'(side_sq);
		end else begin
			node_cnt = NW'(side_sq);
		end
	end

	// Coordinate counter advance, last axis fastest
	always_comb begin
		coord_adv = coord_q;
		if (three_dims_q) begin
			coord_adv[2] = coord_q[2] + CW'(1);
			if (coord_adv[2] >= side) begin
				coord_adv[2] = '0;
				coord_adv[1] = coord_q[1] + CW'(1);
			end
		end else begin
			coord_adv[2] = '0;
			coord_adv[1] = coord_q[1] + CW'(1);
		end
		if (coord_adv[1] >= side) begin
			coord_adv[1] = '0;
			coord_adv[0] = coord_q[0] + CW'(1);
		end
	end

	// Restart, load and immediate results
	always_comb begin
		accept    = start && (state_q == S_IDLE);
		load_full = (CMPW'(load_pos_q) >= CMPW'(node_cnt)) || (32'(load_pos_q) >= MAX_NODES);
		dist_raw  = req.distance;
		dist_mag  = dist_raw[DIST_W-1] ? (~dist_raw + DIST_W'(1)) : dist_raw;
		take      = (dist_mag <= {1'b0, band_limit_q}) && (32'(band_total_q) < MAX_NODES);
		query_oob = QW'(req.entry_index) >= QW'(band_total_q);
		query_go  = 1'b0;

		pos_d   = load_pos_q;
		total_d = band_total_q;
		coord_d = coord_q;
		tbl_we  = 1'b0;
		ent_we  = 1'b0;
		imm_res = '0;

		if (accept) begin
			unique case (req.req_type)
				REQ_RESTART: begin
					pos_d   = '0;
					total_d = '0;
					coord_d = '0;
				end
				REQ_LOAD: begin
					if (load_full) begin
						imm_res.status = STS_LOAD_FULL;
					end else begin
						tbl_we             = 1'b1;
						ent_we             = take;
						imm_res.grid_index = IDX_W'(load_pos_q);
						imm_res.in_band    = take;
						imm_res.band_index = take ? IDX_W'(band_total_q) : '0;
						pos_d              = load_pos_q + PW'(1);
						total_d            = band_total_q + PW'(take);
						coord_d            = coord_adv;
					end
				end
				REQ_QUERY: begin
					if (query_oob) begin
						imm_res.status = STS_QUERY_RANGE;
					end else begin
						query_go = 1'b1;
					end
				end
				default: ;
			endcase
		end
		imm_res.band_count = COUNT_W'(total_d);
	end

	always_comb begin
		tbl_waddr = AW'(load_pos_q);
		tbl_wdata = {take, take ? AW'(band_total_q) : AW'(0)};
		ent_wdata = {AW'(load_pos_q), coord_q[0], coord_q[1], coord_q[2]};
		ent_gidx  = ent_rd_q[ENT_W-1 -: AW];
		ent_coord[0] = ent_rd_q[3*CW-1 -: CW];
		ent_coord[1] = ent_rd_q[2*CW-1 -: CW];
		ent_coord[2] = ent_rd_q[CW-1:0];
	end

	// Node table: valid bit and band index per grid node
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			node_tbl[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rd_q <= node_tbl[tbl_raddr];
		end
	end

	// Band entries: grid index and coordinates per band entry
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[AW'(band_total_q)] <= ent_wdata;
		end
		if (query_go) begin
			ent_rd_q <= entry_mem[AW'(req.entry_index)];
		end
	end

	// Query sequencer: issue one neighbor slot per cycle, then drain
	always_comb begin
		state_d   = state_q;
		slot_d    = slot_q;
		issue     = '0;
		last_slot = three_dims_q ? LAST_SLOT_3D : LAST_SLOT_2D;
		query_end = tag_s2.vld && tag_s2.last;
		unique case (state_q)
			S_IDLE: begin
				if (query_go) begin
					state_d = S_ISSUE;
					slot_d  = '0;
				end
			end
			S_ISSUE: begin
				issue.vld  = 1'b1;
				issue.slot = slot_q;
				issue.last = (slot_q == last_slot);
				slot_d     = slot_q + 3'd1;
				if (issue.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (query_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	nbgc_nbr_pipe #(
		.MAX_NODES    (MAX_NODES),
		.MAX_EXPONENT (MAX_EXPONENT)
	) u_nbr_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.coord      (ent_coord),
		.exp_eff    (exp_eff),
		.side       (side),
		.three_dims (three_dims_q),
		.load_pos   (load_pos_q),
		.tbl_re     (tbl_re),
		.tbl_raddr  (tbl_raddr),
		.tag_s2     (tag_s2)
	);

	// Slot write-back from the node table read
	always_comb begin
		hit  = tag_s2.vld && tag_s2.ok && tbl_rd_q[AW];
		nv_d = nvalid_q;
		nb_d = nbr_q;
		if (tag_s2.vld) begin
			nv_d[tag_s2.slot] = hit;
			nb_d[tag_s2.slot] = hit ? IDX_W'(tbl_rd_q[AW-1:0]) : '0;
		end

		qry_res             = '0;
		qry_res.status      = STS_OK;
		qry_res.grid_index  = IDX_W'(ent_gidx);
		qry_res.nbr_valid   = nv_d;
		qry_res.nbr_plus_i  = nb_d[0];
		qry_res.nbr_minus_i = nb_d[1];
		qry_res.nbr_plus_j  = nb_d[2];
		qry_res.nbr_minus_j = nb_d[3];
		qry_res.nbr_plus_k  = nb_d[4];
		qry_res.nbr_minus_k = nb_d[5];
		qry_res.band_count  = COUNT_W'(band_total_q);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			done_q       <= 1'b0;
			load_pos_q   <= '0;
			band_total_q <= '0;
			coord_q      <= '0;
		end else begin
			state_q      <= state_d;
			slot_q       <= slot_d;
			done_q       <= (accept && !query_go) || query_end;
			load_pos_q   <= pos_d;
			band_total_q <= total_d;
			coord_q      <= coord_d;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		nvalid_q <= nv_d;
		nbr_q    <= nb_d;
		if (query_go) begin
			nvalid_q <= '0;
			nbr_q    <= '0;
		end
		if (accept && !query_go) begin
			res_q <= imm_res;
		end else if (query_end) begin
			res_q <= qry_res;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// Loads and neighbor reads never share a cycle on the node table
	a_tbl_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_we && tbl_re))
		else $error("node table written and read in the same cycle");

	// Band count can never pass the load position
	a_band_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		band_total_q <= load_pos_q)
		else $error("band count above load position");

	// Leaving the query sequence always delivers its result
	a_query_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query finished without a result strobe");

	// A 2D result never flags third-axis neighbors
	a_2d_no_k: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !three_dims_q) |-> (result.nbr_valid[5:4] == 2'b00))
		else $error("third-axis neighbor flagged on a 2D grid");

endmodule

`default_nettype wire

FILE: tb/narrow_band_grid_compaction_test.sv
// Self-checking testbench for narrow_band_grid_compaction: drives restart, load and
// query transactions, predicts every result and compares it field by field.
// Depends on nbgc_pkg and the narrow_band_grid_compaction RTL.
`timescale 1ns / 1ps

module narrow_band_grid_compaction_test;
	import nbgc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1300;
	localparam int AUTO_LOADS   = -1;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic               busy;
	nbgc_in_t           req       = '0;
	logic               done;
	nbgc_out_t          result;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	narrow_band_grid_compaction uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Transactions waiting to be sent, and results owed by the block
	nbgc_in_t  request_backlog [$];
	nbgc_out_t due_replies [$];
	int        fail_count = 0;
	int        queued_total = 0;
	bit        gap_free = 1'b0;

	// Stimulus-side estimate of load position and band size, for picking entries
	int unsigned plan_pos;
	int unsigned plan_band;

	// Shadow copy of the block: configuration, tables and load walker
	logic [LIMIT_W-1:0] lim_q;
	logic               dims3_q;
	logic [EXP_W-1:0]   exp_q;
	bit                 node_in_band [MAX_NODES_DEF];
	int unsigned        node_band [MAX_NODES_DEF];
	int unsigned        entry_grid [MAX_NODES_DEF];
	int                 entry_coord [MAX_NODES_DEF][3];
	int unsigned        next_pos;
	int                 walk_coord [3];
	int unsigned        band_total;

	function automatic int unsigned grid_side();
		int unsigned e;
		e = exp_q;
		if (e < 1) e = 1;
		if (e > MAX_EXPONENT_DEF) e = MAX_EXPONENT_DEF;
		return (1 << e) + 1;
	endfunction

	function automatic int unsigned node_total();
		int unsigned s;
		s = grid_side();
		return dims3_q ? s * s * s : s * s;
	endfunction

	// Band index of the node at coordinates c, if it is loaded and in the band
	function automatic bit neighbor_band(input int c [3], output int unsigned b);
		int unsigned s;
		int unsigned idx;
		int          n_axes;
		s = grid_side();
		n_axes = dims3_q ? 3 : 2;
		idx = 0;
		b = 0;
		for (int d = 0; d < n_axes; d++) begin
			if (c[d] < 0 || c[d] >= int'(s)) return 1'b0;
			idx = idx * s + c[d];
		end
		if (idx >= next_pos || idx >= MAX_NODES_DEF) return 1'b0;
		if (!node_in_band[idx]) return 1'b0;
		b = node_band[idx];
		return 1'b1;
	endfunction

	// Applies one transaction to the shadow state and returns its result
	function automatic nbgc_out_t compute_reply(input nbgc_in_t item);
		nbgc_out_t            r;
		int                   v;
		int unsigned          mag;
		int unsigned          s;
		int unsigned          slots;
		int unsigned          b;
		int                   c [3];
		logic [NBR_SLOTS-1:0] vmask;
		logic [IDX_W-1:0]     nb [NBR_SLOTS];
		r = '0;
		vmask = '0;
		foreach (nb[k]) nb[k] = '0;
		case (item.req_type)
			REQ_RESTART: begin
				next_pos = 0;
				band_total = 0;
				walk_coord = '{0, 0, 0};
			end
			REQ_LOAD: begin
				if (next_pos >= node_total() || next_pos >= MAX_NODES_DEF) begin
					r.status = STS_LOAD_FULL;
				end else begin
					v = $signed(item.distance);
					mag = v < 0 ? -v : v;
					s = grid_side();
					r.grid_index = IDX_W'(next_pos);
					if (mag <= lim_q && band_total < MAX_NODES_DEF) begin
						node_in_band[next_pos] = 1'b1;
						node_band[next_pos] = band_total;
						entry_grid[band_total] = next_pos;
						entry_coord[band_total] = walk_coord;
						r.in_band = 1'b1;
						r.band_index = IDX_W'(band_total);
						band_total++;
					end else begin
						node_in_band[next_pos] = 1'b0;
					end
					next_pos++;
					// row-major walk, last axis fastest, wrapping with the current side
					if (dims3_q) begin
						walk_coord[2]++;
						if (walk_coord[2] >= int'(s)) begin
							walk_coord[2] = 0;
							walk_coord[1]++;
						end
					end else begin
						walk_coord[2] = 0;
						walk_coord[1]++;
					end
					if (walk_coord[1] >= int'(s)) begin
						walk_coord[1] = 0;
						walk_coord[0]++;
					end
				end
			end
			REQ_QUERY: begin
				if (item.entry_index >= band_total) begin
					r.status = STS_QUERY_RANGE;
				end else begin
					r.grid_index = IDX_W'(entry_grid[item.entry_index]);
					slots = dims3_q ? 6 : 4;
					// slot order: +i, -i, +j, -j, +k, -k
					for (int n = 0; n < slots; n++) begin
						c = entry_coord[item.entry_index];
						c[n >> 1] += (n & 1) ? -1 : 1;
						if (neighbor_band(c, b)) begin
							vmask[n] = 1'b1;
							nb[n] = IDX_W'(b);
						end
					end
					r.nbr_valid = vmask;
					r.nbr_plus_i = nb[0];
					r.nbr_minus_i = nb[1];
					r.nbr_plus_j = nb[2];
					r.nbr_minus_j = nb[3];
					r.nbr_plus_k = nb[4];
					r.nbr_minus_k = nb[5];
				end
			end
			default: ;
		endcase
		r.band_count = COUNT_W'(band_total);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Driver: predicts on acceptance, then presents the next transaction or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) due_replies.push_back(compute_reply(req));
			if (!start || !busy) begin
				if (request_backlog.size() != 0 && (gap_free || $urandom_range(99) >= 16)) begin
					start <= 1'b1;
					req <= request_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is matched against the oldest prediction
	always @(posedge clk) begin
		nbgc_out_t want;
		if (arst_n && done) begin
			if (due_replies.size() == 0) begin
				$error("result with no transaction pending");
				fail_count++;
			end else begin
				want = due_replies.pop_front();
				check_field("status", want.status, result.status);
				check_field("in_band", want.in_band, result.in_band);
				check_field("band_index", want.band_index, result.band_index);
				check_field("grid_index", want.grid_index, result.grid_index);
				check_field("nbr_valid", want.nbr_valid, result.nbr_valid);
				check_field("nbr_plus_i", want.nbr_plus_i, result.nbr_plus_i);
				check_field("nbr_minus_i", want.nbr_minus_i, result.nbr_minus_i);
				check_field("nbr_plus_j", want.nbr_plus_j, result.nbr_plus_j);
				check_field("nbr_minus_j", want.nbr_minus_j, result.nbr_minus_j);
				check_field("nbr_plus_k", want.nbr_plus_k, result.nbr_plus_k);
				check_field("nbr_minus_k", want.nbr_minus_k, result.nbr_minus_k);
				check_field("band_count", want.band_count, result.band_count);
			end
		end
	end

	function automatic void queue_item(input logic [1:0] code, input logic [DIST_W-1:0] d,
			input logic [IDX_W-1:0] e);
		nbgc_in_t it;
		it.req_type = code;
		it.distance = d;
		it.entry_index = e;
		request_backlog.push_back(it);
		queued_total++;
	endfunction

	// Query mostly a live band entry, sometimes anything
	function automatic void ask_one();
		logic [IDX_W-1:0] e;
		if (plan_band != 0 && $urandom_range(9) != 0) e = $urandom_range(plan_band - 1);
		else e = $urandom;
		queue_item(REQ_QUERY, $urandom, e);
	endfunction

	// Distances cluster on the band edge, inside the band, and at the extremes
	function automatic logic [DIST_W-1:0] pick_distance(input logic [LIMIT_W-1:0] lim);
		int          v;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35) v = int'(lim) + int'($urandom_range(4)) - 2;
		else if (sel < 65) v = $urandom_range(lim);
		else if (sel < 90) v = $urandom;
		else begin
			case ($urandom_range(3))
				0: v = -8388608;
				1: v = 8388607;
				2: v = 0;
				default: v = int'(lim) + 1;
			endcase
		end
		if ($urandom_range(1)) v = -v;
		return v[DIST_W-1:0];
	endfunction

	task automatic load_nodes(input int count, input bit noisy);
		logic [DIST_W-1:0] d;
		int                v;
		int unsigned       roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (noisy && roll < 4) begin
				ask_one();
			end else if (noisy && roll < 6) begin
				queue_item(REQ_UNUSED, $urandom, $urandom);
			end else if (noisy && roll == 6) begin
				queue_item(REQ_RESTART, $urandom, $urandom);
				plan_pos = 0;
				plan_band = 0;
			end
			d = pick_distance(lim_q);
			queue_item(REQ_LOAD, d, $urandom);
			v = $signed(d);
			if (plan_pos < node_total() && plan_pos < MAX_NODES_DEF) begin
				if ((v < 0 ? -v : v) <= int'(lim_q)) plan_band++;
				plan_pos++;
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] which, input logic [LIMIT_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (which)
			CFG_BAND_LIMIT: lim_q = value;
			CFG_THREE_DIMS: dims3_q = value[0];
			CFG_GRID_EXP:   exp_q = value[EXP_W-1:0];
			default: ;
		endcase
	endtask

	// Block is idle once nothing is queued, presented or owed
	task automatic wait_idle();
		while (request_backlog.size() != 0 || start || due_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One phase: new settings, optional restart, loads, then queries
	task automatic run_phase(input logic [EXP_W-1:0] e, input bit three,
			input logic [LIMIT_W-1:0] lim, input bit restart, input int loads,
			input int queries, input bit noisy);
		int unsigned nodes;
		wait_idle();
		write_reg(CFG_GRID_EXP, LIMIT_W'({$urandom, e}));
		write_reg(CFG_THREE_DIMS, LIMIT_W'({$urandom, three}));
		write_reg(CFG_BAND_LIMIT, lim);
		plan_pos = next_pos;
		plan_band = band_total;
		if (restart) begin
			queue_item(REQ_RESTART, $urandom, $urandom);
			plan_pos = 0;
			plan_band = 0;
		end
		if (loads == AUTO_LOADS) begin
			nodes = node_total();
			if (!restart) loads = $urandom_range(12);
			else if (nodes <= 130)
				loads = nodes + ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
			else loads = $urandom_range(30, 130);
		end
		load_nodes(loads, noisy);
		repeat (queries) ask_one();
	endtask

	initial begin
		int                 base;
		int unsigned        roll;
		logic [EXP_W-1:0]   e;
		logic [LIMIT_W-1:0] lim;
		lim_q = '0;
		dims3_q = 1'b0;
		exp_q = EXP_W'(4);
		next_pos = 0;
		band_total = 0;
		walk_coord = '{0, 0, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty band, unused code, load under reset settings
		queue_item(REQ_QUERY, $urandom, '0);
		queue_item(REQ_UNUSED, $urandom, $urandom);
		queue_item(REQ_LOAD, '0, $urandom);
		wait_idle();
		write_reg(CFG_UNUSED, $urandom);

		// Exponent zero acts as one: 3x3 grid, band limit 1.0
		lim = LIMIT_W'(24'h010000);
		run_phase('0, 1'b0, lim, 1'b1, 0, 0, 1'b0);
		foreach (pick_edges[i]) queue_item(REQ_LOAD, pick_edges[i], $urandom);
		queue_item(REQ_LOAD, '0, $urandom);
		queue_item(REQ_QUERY, $urandom, 13'd0);
		queue_item(REQ_QUERY, $urandom, 13'd2);
		queue_item(REQ_QUERY, $urandom, 13'd4);
		queue_item(REQ_QUERY, $urandom, 13'd5);
		queue_item(REQ_QUERY, $urandom, '1);

		// Extremes: largest exponent code with a partial load, widest band;
		// smallest cube with zero band and loads past capacity
		run_phase(EXP_W'(7), 1'b0, '1, 1'b1, 100, 12, 1'b1);
		run_phase(EXP_W'(1), 1'b1, '0, 1'b1, 29, 10, 1'b0);

		// Random phases, mostly small grids and complete loads
		base = queued_total;
		while (queued_total - base < RANDOM_ITEMS) begin
			roll = $urandom_range(19);
			if (roll < 10) e = 1;
			else if (roll < 15) e = 2;
			else if (roll < 17) e = 3;
			else if (roll == 17) e = 0;
			else if (roll == 18) e = 7;
			else e = $urandom_range(4, 6);
			case ($urandom_range(3))
				0: lim = '0;
				1: lim = '1;
				2: lim = $urandom_range(20'hFFFFF);
				default: lim = $urandom;
			endcase
			run_phase(e, $urandom_range(1), lim, $urandom_range(99) < 85, AUTO_LOADS,
				$urandom_range(4, 16), 1'b1);
		end

		// Back-to-back fill of the node table up to its capacity
		wait_idle();
		gap_free = 1'b1;
		run_phase(EXP_W'(6), 1'b1, '1, 1'b1, MAX_NODES_DEF + 2, 8, 1'b0);
		queue_item(REQ_QUERY, $urandom, '1);
		queue_item(REQ_QUERY, $urandom, '0);
		queue_item(REQ_QUERY, $urandom, 13'd4160);
		wait_idle();
		gap_free = 1'b0;

		repeat (12) @(posedge clk);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	// Edge distances for the 3x3 directed grid: on the limit, just past it,
	// both extremes, and the center node in the band
	logic [DIST_W-1:0] pick_edges [8] = '{
		24'h010000, 24'hFF0000, 24'h010001, 24'h800000,
		24'h000000, 24'h7FFFFF, 24'hFFFFFF, 24'hFEFFFF
	};

	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
